// File: rtl/sclru_pkg.sv
// sclru_pkg: shared constants and types for the sector cache lru table
// no dependencies
`default_nettype none
package sclru_pkg;
    localparam int unsigned ROWS_DEF          = 64;
    localparam logic [31:0] STAMP_HALFWAY_DEF = 32'd2147483647;
    localparam logic [31:0] STAMP_REBASE_DEF  = 32'd1073741824;
    localparam logic [31:0] STAMP_CEILING_DEF = 32'd4294967294;
    localparam logic [31:0] LOCKED_STAMP      = 32'hFFFF_FFFF;
    localparam int unsigned FILE_W            = 16;
    localparam int unsigned SECTOR_W          = 31;
    localparam int unsigned STAMP_W           = 32;
    localparam logic [6:0]  ROWS_IN_USE_RST   = 7'd64;

    typedef enum logic [2:0] {
        OP_LOOKUP   = 3'd0,
        OP_LOCK     = 3'd1,
        OP_UNLOCK   = 3'd2,
        OP_INVAL    = 3'd3,
        OP_ALLOC    = 3'd4,
        OP_LOCK_ROW = 3'd5,
        OP_NOP6     = 3'd6,
        OP_NOP7     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_ROW   = 2'd2
    } t_status;

    localparam logic [1:0] REG_ROWS_IN_USE = 2'd0;
endpackage
`default_nettype wire

// File: rtl/sector_cache_lru_table.sv
// sector_cache_lru_table: row table with timestamp lru allocation and locking
// depends on sclru_pkg
//
// channel  | direction | handshake            | payload
// request  | in        | i_start, o_busy      | i_op, i_file_id, i_sector, i_row_index
// result   | out       | o_done (one cycle)   | o_status, o_row
// config   | in        | apb psel/penable     | rows_in_use at byte address 0
//
// a request scans the rows in use through one read port of the row memories,
// one row per cycle; lookup, lock and unlock stop at the first match, invalidate
// scans them all, and allocate may follow the search with a rebase sweep
// (rows in use are capped at ROWS). lock row and unused opcodes skip the scan.
// after reset a clearing pass over all ROWS rows empties the memories; busy stays
// high meanwhile. results cannot be stalled.
`default_nettype none
module sector_cache_lru_table #(
    parameter int unsigned ROWS          = sclru_pkg::ROWS_DEF,
    parameter logic [31:0] STAMP_HALFWAY = sclru_pkg::STAMP_HALFWAY_DEF,
    parameter logic [31:0] STAMP_REBASE  = sclru_pkg::STAMP_REBASE_DEF,
    parameter logic [31:0] STAMP_CEILING = sclru_pkg::STAMP_CEILING_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_op,
    input  wire logic [15:0] i_file_id,
    input  wire logic [30:0] i_sector,
    input  wire logic [5:0]  i_row_index,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [5:0]       o_row,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int unsigned AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned CW = $clog2(ROWS + 1);
    localparam int unsigned EW = sclru_pkg::FILE_W + sclru_pkg::SECTOR_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_REBASE, S_WRITE, S_DONE
    } t_state;

    // row memory: valid, file, sector; stamp memory separate
    logic [EW-1:0]                   r_ent_mem [ROWS];
    logic [sclru_pkg::STAMP_W-1:0]   r_stp_mem [ROWS];

    t_state                 r_state;
    logic [6:0]             r_rows_cfg;
    logic [2:0]             r_op;
    logic [15:0]            r_file;
    logic [30:0]            r_sector;
    logic [5:0]             r_ridx;
    logic [31:0]            r_clock;
    logic [CW-1:0]          r_cnt;
    logic                   r_rd_vld;
    logic [AW-1:0]          r_rd_idx;
    logic [EW-1:0]          r_ent_q;
    logic [31:0]            r_stp_q;
    logic                   r_found;
    logic [AW-1:0]          r_sel;
    logic [31:0]            r_oldest;
    logic [1:0]             r_status;
    logic [5:0]             r_row;
    logic                   r_done;

    logic [CW-1:0]          active_n;
    logic                   rd_en;
    logic [AW-1:0]          rd_idx;
    logic                   ent_we, stp_we;
    logic [AW-1:0]          ent_wa, stp_wa;
    logic [EW-1:0]          ent_wd;
    logic [31:0]            stp_wd;
    logic                   hit;
    logic                   scan_hit;
    logic                   start_ok;
    logic                   cfg_wr;

    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = (paddr == 1'b0) ? {25'd0, r_rows_cfg} : 32'd0;
    assign o_busy  = (r_state != S_IDLE);
    assign start_ok = i_start && !o_busy;
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_row    = r_row;

    always_comb begin
        if ({25'd0, r_rows_cfg} > ROWS) active_n = CW'(ROWS);
        else                            active_n = CW'(r_rows_cfg);
    end

    assign hit = r_ent_q[EW-1] && (r_ent_q[EW-2 -: 16] == r_file)
                 && (r_ent_q[30:0] == r_sector);

    // first match of lookup, lock or unlock
    assign scan_hit = (r_state == S_SCAN) && r_rd_vld && (r_op != sclru_pkg::OP_ALLOC)
                      && (r_op != sclru_pkg::OP_INVAL) && hit && !r_found;

    // issue reads in scan and rebase states, one row per cycle
    always_comb begin
        rd_en  = ((r_state == S_SCAN) || (r_state == S_REBASE)) && (r_cnt < active_n)
                 && !scan_hit;
        rd_idx = r_cnt[AW-1:0];
    end

    // memory write port selection
    always_comb begin
        ent_we = 1'b0;
        ent_wa = r_rd_idx;
        ent_wd = '0;
        stp_we = 1'b0;
        stp_wa = r_rd_idx;
        stp_wd = '0;
        unique case (r_state)
            S_CLEAR: begin
                ent_we = 1'b1;
                ent_wa = r_cnt[AW-1:0];
                stp_we = 1'b1;
                stp_wa = r_cnt[AW-1:0];
            end
            S_SCAN: begin
                if (r_rd_vld && r_op == sclru_pkg::OP_INVAL && r_ent_q[EW-1]
                    && r_ent_q[EW-2 -: 16] == r_file) begin
                    ent_we = 1'b1;
                    stp_we = 1'b1;
                end
            end
            S_REBASE: begin
                if (r_rd_vld && r_stp_q > STAMP_HALFWAY
                    && r_stp_q != sclru_pkg::LOCKED_STAMP) begin
                    stp_we = 1'b1;
                    stp_wd = r_stp_q - STAMP_REBASE;
                end
            end
            S_WRITE: begin
                stp_wa = r_sel;
                ent_wa = r_sel;
                unique case (r_op)
                    sclru_pkg::OP_LOOKUP: begin
                        stp_we = r_found && r_stp_q != sclru_pkg::LOCKED_STAMP;
                        stp_wd = r_clock;
                    end
                    sclru_pkg::OP_LOCK: begin
                        stp_we = r_found;
                        stp_wd = sclru_pkg::LOCKED_STAMP;
                    end
                    sclru_pkg::OP_UNLOCK: begin
                        stp_we = r_found;
                        stp_wd = (r_stp_q != sclru_pkg::LOCKED_STAMP)
                                 ? r_clock + 32'd1 : r_clock;
                    end
                    sclru_pkg::OP_ALLOC: begin
                        stp_we = r_found;
                        stp_wd = r_clock;
                        ent_we = r_found;
                        ent_wd = {1'b1, r_file, r_sector};
                    end
                    sclru_pkg::OP_LOCK_ROW: begin
                        stp_we = ({26'd0, r_ridx} < ROWS);
                        stp_wa = r_ridx[AW-1:0];
                        stp_wd = sclru_pkg::LOCKED_STAMP;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_ent_q <= r_ent_mem[rd_idx];
            r_stp_q <= r_stp_mem[rd_idx];
        end
        if (ent_we) r_ent_mem[ent_wa] <= ent_wd;
        if (stp_we) r_stp_mem[stp_wa] <= stp_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_rows_cfg <= sclru_pkg::ROWS_IN_USE_RST;
            r_clock    <= 32'd1;
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_done     <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            if (cfg_wr && paddr == sclru_pkg::REG_ROWS_IN_USE[0]) r_rows_cfg <= pwdata[6:0];
            r_rd_vld <= rd_en;
            r_rd_idx <= rd_idx;
            r_done   <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(ROWS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start_ok) begin
                        r_op     <= i_op;
                        r_file   <= i_file_id;
                        r_sector <= i_sector;
                        r_ridx   <= i_row_index;
                        r_cnt    <= '0;
                        r_found  <= 1'b0;
                        r_oldest <= STAMP_CEILING;
                        if (i_op == sclru_pkg::OP_LOCK_ROW || i_op == sclru_pkg::OP_NOP6
                            || i_op == sclru_pkg::OP_NOP7) r_state <= S_WRITE;
                        else r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rd_en) r_cnt <= r_cnt + CW'(1);
                    if (r_rd_vld) begin
                        priority if (r_op == sclru_pkg::OP_ALLOC) begin
                            if (r_stp_q < r_oldest) begin
                                r_oldest <= r_stp_q;
                                r_sel    <= r_rd_idx;
                                r_found  <= 1'b1;
                            end
                        end else if (r_op != sclru_pkg::OP_INVAL && hit && !r_found) begin
                            r_found <= 1'b1;
                            r_sel   <= r_rd_idx;
                        end else begin
                        end
                    end
                    // stop early on a lookup-type hit, with data still registered
                    if (scan_hit) begin
                        r_state <= S_WRITE;
                    end else if (!rd_en && !r_rd_vld) begin
                        if (r_op == sclru_pkg::OP_ALLOC && r_found
                            && r_oldest > STAMP_HALFWAY && r_oldest != STAMP_CEILING) begin
                            r_cnt    <= '0;
                            r_state  <= S_REBASE;
                        end else begin
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_REBASE: begin
                    if (rd_en) r_cnt <= r_cnt + CW'(1);
                    if (!rd_en && !r_rd_vld) begin
                        if (r_clock > STAMP_HALFWAY) r_clock <= r_clock - STAMP_REBASE;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_status <= sclru_pkg::ST_OK;
                    r_row    <= '0;
                    unique case (r_op)
                        sclru_pkg::OP_LOOKUP, sclru_pkg::OP_LOCK, sclru_pkg::OP_UNLOCK: begin
                            if (r_found) begin
                                r_row <= 6'(r_sel);
                                r_clock <= r_clock
                                    + ((r_stp_q != sclru_pkg::LOCKED_STAMP) ? 32'd1 : 32'd0)
                                    + ((r_op == sclru_pkg::OP_UNLOCK) ? 32'd1 : 32'd0);
                            end else begin
                                r_status <= sclru_pkg::ST_NOT_FOUND;
                            end
                        end
                        sclru_pkg::OP_ALLOC: begin
                            if (r_found) begin
                                r_row   <= 6'(r_sel);
                                r_clock <= r_clock + 32'd1;
                            end else begin
                                r_status <= sclru_pkg::ST_NO_ROW;
                            end
                        end
                        sclru_pkg::OP_LOCK_ROW: begin
                            if ({26'd0, r_ridx} < ROWS) r_row <= r_ridx;
                            else r_status <= sclru_pkg::ST_NOT_FOUND;
                        end
                        default: ;
                    endcase
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("result strobe held");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> o_busy) else $error("scan while idle");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_status != 2'd3)) else $error("bad status");
    a_rebase_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REBASE) |-> (r_op == sclru_pkg::OP_ALLOC))
        else $error("rebase outside allocate");
endmodule
`default_nettype wire
